// ===== rtl/core/scfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling chart frame buffer package
// Shared types and byte constants for the frame buffer unit, its cells and planes.
// ----------------------------------------------------------------------------
package scfb_pkg;

    localparam int HIT_IDX_W = 8;

    localparam logic [7:0] BYTE_UNLIT = 8'hff;
    localparam logic [7:0] MSB_MASK   = 8'b1000_0000;
    localparam logic [7:0] LSB_MASK   = 8'b0000_0001;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PLOT,
        CELL_SCROLL,
        CELL_ROTATE
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_cell_op               op;
        logic                   hit;
        logic [HIT_IDX_W-1:0]   hit_idx;
        logic [7:0]             mask;
    } t_plane_ctrl;

endpackage

// ===== rtl/core/scfb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer cell
// One active-low pixel byte that can be cleared, scrolled or rotated.
// ----------------------------------------------------------------------------
module scfb_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scfb_pkg::t_cell_op i_op,
    input  logic [7:0]        i_next,
    input  logic              i_carry,
    input  logic [7:0]        i_clr_mask,
    output logic [7:0]        o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        case (i_op)
            scfb_pkg::CELL_PLOT:   n_byte = r_byte & ~i_clr_mask;
            scfb_pkg::CELL_SCROLL: n_byte = {r_byte[6:0], i_carry} & ~i_clr_mask;
            scfb_pkg::CELL_ROTATE: n_byte = i_next;
            default:               n_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= scfb_pkg::BYTE_UNLIT;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ===== rtl/core/scfb_plane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer plane
// A chain of byte cells holding one scan plane, with scroll carries between
// column groups and a rotating path that brings each byte to the head.
// ----------------------------------------------------------------------------
module scfb_plane #(
    parameter int PLANE_BYTES = 16,
    parameter int STRIDE      = 4,
    parameter int COL_GROUPS  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scfb_pkg::t_plane_ctrl i_ctrl,
    output logic [7:0]            o_head
);

    logic [7:0] w_bytes [PLANE_BYTES];

    for (genvar i = 0; i < PLANE_BYTES; i++) begin : g_cell
        logic       w_carry;
        logic [7:0] w_clr_mask;

        if ((i / STRIDE + 1 < COL_GROUPS) && (i + STRIDE < PLANE_BYTES)) begin : g_link
            assign w_carry = w_bytes[i + STRIDE][7];
        end else begin : g_edge
            assign w_carry = 1'b1;
        end

        assign w_clr_mask = (i_ctrl.hit && (int'(i_ctrl.hit_idx) == i)) ? i_ctrl.mask
                                                                        : 8'h00;

        scfb_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_op       (i_ctrl.op),
            .i_next     (w_bytes[(i + 1) % PLANE_BYTES]),
            .i_carry    (w_carry),
            .i_clr_mask (w_clr_mask),
            .o_byte     (w_bytes[i])
        );
    end

    assign o_head = w_bytes[0];

endmodule

// ===== rtl/core/scrolling_chart_frame_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scrolling chart frame buffer
// Strip-chart image store for a multiplexed LED panel, held in byte cells.
// ----------------------------------------------------------------------------
// The input channel carries one item per command: tuser selects plot (0) or
// scan (1), tdata carries the point column and row. In a plot, a repeated
// point is dropped, an in-range column clears one pixel, and a column at or
// beyond the panel width scrolls every plane left by one column and lights
// the new point in the last column, both in the same cycle.
// A scan streams the PLANE_BYTES bytes of the current plane on the output
// channel, one byte per accepted output item, together with the A/B
// row-select levels, with tlast on the final byte. The first byte is offered
// the cycle after the scan item is accepted; a scan occupies the block for
// PLANE_BYTES output transfers, set by the rotation of the plane's cell
// chain that brings each byte to the head cell. No input item is taken
// while a scan is in progress.
// When the receiver stalls, the chain holds and the byte stays on tdata.
// Reset clears all cells to unlit, the previous point to (0, 0) and the
// scan phase to plane 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module scrolling_chart_frame_buffer_unit #(
    parameter int PANEL_COLUMNS = 32,
    parameter int PLANE_BYTES   = 16,
    parameter int SCAN_PLANES   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // col[15:0], row[19:16], zero pad
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_byte[7:0], line_a[8], line_b[9], zero pad
    output logic        m_axis_tlast
);

    localparam int STRIDE     = (16 + SCAN_PLANES - 1) / SCAN_PLANES;
    localparam int COL_GROUPS = PANEL_COLUMNS / 8;
    localparam int PH_W       = $clog2(SCAN_PLANES);
    localparam int CNT_W      = $clog2(PLANE_BYTES);

    scfb_pkg::t_state      r_state;
    scfb_pkg::t_state      n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [PH_W-1:0]       r_phase;
    logic [PH_W-1:0]       n_phase;
    logic [15:0]           r_last_col;
    logic [15:0]           n_last_col;
    logic [3:0]            r_last_row;
    logic [3:0]            n_last_row;

    scfb_pkg::t_plane_ctrl w_ctrl [SCAN_PLANES];
    logic [7:0]            w_head [SCAN_PLANES];

    logic [15:0]           w_col;
    logic [3:0]            w_row;
    logic                  w_in_acc;
    logic [PH_W-1:0]       w_plane;
    logic [7:0]            w_rgrp;
    logic [7:0]            w_idx;
    logic [7:0]            w_scroll_idx;
    logic [7:0]            w_mask;
    logic [1:0]            w_phase_ext;

    assign w_col    = s_axis_tdata[15:0];
    assign w_row    = s_axis_tdata[19:16];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_plane = '0;
        w_rgrp  = '0;
        for (int r = 0; r < 16; r++) begin
            if (w_row == 4'(r)) begin
                w_plane = PH_W'(r % SCAN_PLANES);
                w_rgrp  = 8'(r / SCAN_PLANES);
            end
        end
    end

    assign w_idx        = 8'(int'(w_col[7:3]) * STRIDE + int'(w_rgrp));
    assign w_scroll_idx = 8'((COL_GROUPS - 1) * STRIDE + int'(w_rgrp));
    assign w_mask       = scfb_pkg::MSB_MASK >> w_col[2:0];

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_phase       = r_phase;
        n_last_col    = r_last_col;
        n_last_row    = r_last_row;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        for (int p = 0; p < SCAN_PLANES; p++) begin
            w_ctrl[p].op      = scfb_pkg::CELL_HOLD;
            w_ctrl[p].hit     = 1'b0;
            w_ctrl[p].hit_idx = '0;
            w_ctrl[p].mask    = '0;
        end
        case (r_state)
            scfb_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_acc && s_axis_tuser) begin
                    n_state = scfb_pkg::ST_SCAN;
                    n_cnt   = '0;
                end else if (w_in_acc &&
                             !(w_col == r_last_col && w_row == r_last_row)) begin
                    n_last_col = w_col;
                    n_last_row = w_row;
                    for (int p = 0; p < SCAN_PLANES; p++) begin
                        if (w_col < 16'(PANEL_COLUMNS)) begin
                            w_ctrl[p].op      = scfb_pkg::CELL_PLOT;
                            w_ctrl[p].hit_idx = w_idx;
                            w_ctrl[p].mask    = w_mask;
                        end else begin
                            w_ctrl[p].op      = scfb_pkg::CELL_SCROLL;
                            w_ctrl[p].hit_idx = w_scroll_idx;
                            w_ctrl[p].mask    = scfb_pkg::LSB_MASK;
                        end
                        w_ctrl[p].hit = (w_plane == PH_W'(p)) && (COL_GROUPS > 0);
                    end
                end
            end
            scfb_pkg::ST_SCAN: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    for (int p = 0; p < SCAN_PLANES; p++) begin
                        if (r_phase == PH_W'(p)) begin
                            w_ctrl[p].op = scfb_pkg::CELL_ROTATE;
                        end
                    end
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(PLANE_BYTES - 1)) begin
                        n_state = scfb_pkg::ST_IDLE;
                        n_cnt   = '0;
                        n_phase = (r_phase == PH_W'(SCAN_PLANES - 1)) ? '0
                                                                      : r_phase + 1'b1;
                    end
                end
            end
            default: begin
                n_state = scfb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= scfb_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_phase    <= '0;
            r_last_col <= '0;
            r_last_row <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_phase    <= n_phase;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
        end
    end

    for (genvar p = 0; p < SCAN_PLANES; p++) begin : g_plane
        scfb_plane #(
            .PLANE_BYTES (PLANE_BYTES),
            .STRIDE      (STRIDE),
            .COL_GROUPS  (COL_GROUPS)
        ) u_plane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[p]),
            .o_head  (w_head[p])
        );
    end

    assign w_phase_ext  = 2'(r_phase);
    assign m_axis_tdata = {6'b0, ~w_phase_ext[1], ~w_phase_ext[0], w_head[r_phase]};
    assign m_axis_tlast = (r_cnt == CNT_W'(PLANE_BYTES - 1));

endmodule
